// ----- rtl/fdr_pkg.sv -----
// shared constants and pipeline side-data type for the fresnel reflectance unit
package fdr_pkg;

  localparam int unsigned COS_W       = 16;
  localparam int unsigned IDX_W       = 16;
  localparam int unsigned REFL_W      = 16;
  localparam int unsigned MAG_W       = 15;   // |cos| up to 16384
  localparam int unsigned WIDE_W      = 60;   // sine-squared products, sqrt radicand
  localparam int unsigned ROOT_W      = 30;
  localparam int unsigned DEN_W       = 48;
  localparam int unsigned REM_W       = 49;
  localparam int unsigned Q_W         = 17;   // ratio magnitude, Q1.16
  localparam int unsigned SQRT_STEPS  = 30;
  localparam int unsigned DIV_STEPS   = 17;

  localparam logic signed [COS_W:0] COS_ONE  = 17'sd16384;
  localparam logic [REFL_W-1:0]     REFL_ONE = 16'd32768;

  // data riding alongside the square-root stages
  typedef struct packed {
    logic [IDX_W-1:0] ni;
    logic [31:0]      nt2;
    logic [MAG_W-1:0] c;
    logic             tir;
  } fdr_side_t;

endpackage

// ----- rtl/fresnel_dielectric_reflectance_unit.sv -----
// top level: pipelined unpolarised fresnel reflectance of a dielectric boundary
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+-----
//  in      | in_valid, in_ready, in_cos_incident,               | in
//          | in_index_outside, in_index_inside                  |
//  out     | out_valid, out_ready, out_reflectance,             | out
//          | out_total_internal                                 |
//
// one word enters per cycle while the output is not stalled; the pipe includes the 30 square-root
// stages (one root bit each) and the 17 divider stages (one quotient bit each)
// the whole pipe advances together; when out_valid is high and out_ready low
// every stage holds and in_ready drops, so nothing is lost or repeated
// rst_n (synchronous) clears all stage valid bits; payload registers are not reset
module fresnel_dielectric_reflectance_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [15:0]         in_cos_incident,
  input  logic        [15:0]         in_index_outside,
  input  logic        [15:0]         in_index_inside,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic        [15:0]         out_reflectance,
  output logic                       out_total_internal
);

  localparam int unsigned NS = fdr_pkg::SQRT_STEPS;
  localparam int unsigned ND = fdr_pkg::DIV_STEPS;

  logic adv;
  logic out_valid_r;
  logic [fdr_pkg::REFL_W-1:0] out_refl_r;
  logic out_tir_r;

  // global advance: pipe moves unless the output word is stuck
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: clamp, direction, index swap ----------------
  logic signed [fdr_pkg::COS_W:0] cs_ext, cs_cl;
  logic                           enter;
  logic [fdr_pkg::MAG_W-1:0]      c_mag;

  always_comb begin
    cs_ext = {in_cos_incident[15], in_cos_incident};
    if (cs_ext > fdr_pkg::COS_ONE)       cs_cl = fdr_pkg::COS_ONE;
    else if (cs_ext < -fdr_pkg::COS_ONE) cs_cl = -fdr_pkg::COS_ONE;
    else                                 cs_cl = cs_ext;
    enter = (cs_cl > 17'sd0);
    c_mag = enter ? cs_cl[fdr_pkg::MAG_W-1:0] : fdr_pkg::MAG_W'(-cs_cl);
  end

  logic                        v1_r;
  logic [15:0]                 ni1_r, nt1_r;
  logic [fdr_pkg::MAG_W-1:0]   c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      ni1_r <= enter ? in_index_outside : in_index_inside;
      nt1_r <= enter ? in_index_inside  : in_index_outside;
      c1_r  <= c_mag;
    end
  end

  // ---------------- stage 2: squares ----------------
  logic                       v2_r;
  logic [28:0]                cc2_r;
  logic [31:0]                ni2_2_r, nt2_2_r;
  logic [15:0]                ni2_r;
  logic [fdr_pkg::MAG_W-1:0]  c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      cc2_r   <= 29'(c1_r * c1_r);
      ni2_2_r <= ni1_r * ni1_r;
      nt2_2_r <= nt1_r * nt1_r;
      ni2_r   <= ni1_r;
      c2_r    <= c1_r;
    end
  end

  // ---------------- stage 3: ni^2 * sin^2 and nt^2 scaled ----------------
  logic [28:0]                s2;
  logic                       v3_r;
  logic [60:0]                lhs3_r;
  logic [fdr_pkg::WIDE_W-1:0] rhs3_r;
  fdr_pkg::fdr_side_t         side3_r;

  assign s2 = 29'h1000_0000 - cc2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      lhs3_r      <= 61'(ni2_2_r * s2);
      rhs3_r      <= {nt2_2_r, 28'd0};
      side3_r.ni  <= ni2_r;
      side3_r.nt2 <= nt2_2_r;
      side3_r.c   <= c2_r;
      side3_r.tir <= 1'b0;
    end
  end

  // ---------------- stage 4: tir test, radicand ----------------
  logic                       sq_v_r [0:NS];
  logic [fdr_pkg::WIDE_W-1:0] sq_rem_r [0:NS];
  logic [fdr_pkg::WIDE_W-1:0] sq_root_r [0:NS];
  fdr_pkg::fdr_side_t         sq_side_r [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= v3_r;
    end
    if (adv) begin
      sq_side_r[0].ni  <= side3_r.ni;
      sq_side_r[0].nt2 <= side3_r.nt2;
      sq_side_r[0].c   <= side3_r.c;
      sq_side_r[0].tir <= (lhs3_r >= {1'b0, rhs3_r});
      sq_rem_r[0]      <= fdr_pkg::WIDE_W'({1'b0, rhs3_r} - lhs3_r);
      sq_root_r[0]     <= '0;
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam logic [fdr_pkg::WIDE_W:0] BIT = (fdr_pkg::WIDE_W+1)'(1) << (58 - 2*k);
    logic [fdr_pkg::WIDE_W:0]   trial;
    logic                       ge;
    always_comb begin
      trial = {1'b0, sq_root_r[k]} + BIT;
      ge    = ({1'b0, sq_rem_r[k]} >= trial);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
      if (adv) begin
        sq_side_r[k+1] <= sq_side_r[k];
        if (ge) begin
          sq_rem_r[k+1]  <= fdr_pkg::WIDE_W'({1'b0, sq_rem_r[k]} - trial);
          sq_root_r[k+1] <= fdr_pkg::WIDE_W'({2'b0, sq_root_r[k][fdr_pkg::WIDE_W-1:1]} + BIT);
        end else begin
          sq_rem_r[k+1]  <= sq_rem_r[k];
          sq_root_r[k+1] <= {1'b0, sq_root_r[k][fdr_pkg::WIDE_W-1:1]};
        end
      end
    end
  end

  // ---------------- products for the two amplitude ratios ----------------
  logic [fdr_pkg::ROOT_W-1:0] t_root;
  assign t_root = sq_root_r[NS][fdr_pkg::ROOT_W-1:0];

  logic                      vm_r, tirm_r;
  logic [46:0]               pa_m_r;   // nt^2 * c
  logic [45:0]               pb_m_r;   // ni * t
  logic [30:0]               sa_m_r;   // ni * c
  logic [fdr_pkg::ROOT_W-1:0] sb_m_r;  // t

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (adv) begin
      vm_r <= sq_v_r[NS];
    end
    if (adv) begin
      pa_m_r <= 47'(sq_side_r[NS].nt2 * sq_side_r[NS].c);
      pb_m_r <= sq_side_r[NS].ni * t_root;
      sa_m_r <= sq_side_r[NS].ni * sq_side_r[NS].c;
      sb_m_r <= t_root;
      tirm_r <= sq_side_r[NS].tir;
    end
  end

  // ---------------- numerators and denominators ----------------
  logic                        dv_r   [0:ND];
  logic                        dtir_r [0:ND];
  logic [fdr_pkg::DEN_W-1:0]   pden_r [0:ND];
  logic [fdr_pkg::DEN_W-1:0]   sden_r [0:ND];
  logic [fdr_pkg::REM_W-1:0]   prem_r [0:ND];
  logic [fdr_pkg::REM_W-1:0]   srem_r [0:ND];
  logic [fdr_pkg::Q_W-1:0]     pq_r   [0:ND];
  logic [fdr_pkg::Q_W-1:0]     sq_q_r [0:ND];

  logic [fdr_pkg::DEN_W-1:0] pa_w, pb_w, sa_w, sb_w;
  assign pa_w = fdr_pkg::DEN_W'(pa_m_r);
  assign pb_w = fdr_pkg::DEN_W'(pb_m_r);
  assign sa_w = fdr_pkg::DEN_W'(sa_m_r);
  assign sb_w = fdr_pkg::DEN_W'(sb_m_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= vm_r;
    end
    if (adv) begin
      dtir_r[0] <= tirm_r;
      pden_r[0] <= pa_w + pb_w;
      sden_r[0] <= sa_w + sb_w;
      prem_r[0] <= fdr_pkg::REM_W'((pa_w >= pb_w) ? (pa_w - pb_w) : (pb_w - pa_w));
      srem_r[0] <= fdr_pkg::REM_W'((sa_w >= sb_w) ? (sa_w - sb_w) : (sb_w - sa_w));
      pq_r[0]   <= '0;
      sq_q_r[0] <= '0;
    end
  end

  // ---------------- restoring division, one quotient bit per stage ----------------
  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [fdr_pkg::REM_W-1:0] ps, ss;
    logic                      pge, sge;
    always_comb begin
      if (k == 0) begin
        ps = prem_r[k];
        ss = srem_r[k];
      end else begin
        ps = {prem_r[k][fdr_pkg::REM_W-2:0], 1'b0};
        ss = {srem_r[k][fdr_pkg::REM_W-2:0], 1'b0};
      end
      pge = (ps >= {1'b0, pden_r[k]});
      sge = (ss >= {1'b0, sden_r[k]});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_r[k+1] <= dv_r[k];
      end
      if (adv) begin
        dtir_r[k+1] <= dtir_r[k];
        pden_r[k+1] <= pden_r[k];
        sden_r[k+1] <= sden_r[k];
        prem_r[k+1] <= pge ? (ps - {1'b0, pden_r[k]}) : ps;
        srem_r[k+1] <= sge ? (ss - {1'b0, sden_r[k]}) : ss;
        pq_r[k+1]   <= {pq_r[k][fdr_pkg::Q_W-2:0], pge};
        sq_q_r[k+1] <= {sq_q_r[k][fdr_pkg::Q_W-2:0], sge};
      end
    end
  end

  // a zero denominator (0/0) counts as magnitude one
  logic [fdr_pkg::Q_W-1:0] qp, qs;
  assign qp = (pden_r[ND] == '0) ? fdr_pkg::Q_W'(17'h10000) : pq_r[ND];
  assign qs = (sden_r[ND] == '0) ? fdr_pkg::Q_W'(17'h10000) : sq_q_r[ND];

  // ---------------- squares of the ratios ----------------
  logic        vs_r, tirs_r;
  logic [33:0] psq_r, ssq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else if (adv) begin
      vs_r <= dv_r[ND];
    end
    if (adv) begin
      psq_r  <= 34'(qp * qp);
      ssq_r  <= 34'(qs * qs);
      tirs_r <= dtir_r[ND];
    end
  end

  // ---------------- mean, round half up, saturate, tir forces one; output register ----------------
  logic [34:0]                 sum;
  logic [16:0]                 refl_w;
  logic [fdr_pkg::REFL_W-1:0]  refl_sat;

  always_comb begin
    sum    = {1'b0, psq_r} + {1'b0, ssq_r} + 35'h2_0000;
    refl_w = sum[34:18];
    refl_sat = (refl_w > {1'b0, fdr_pkg::REFL_ONE}) ? fdr_pkg::REFL_ONE
                                                   : refl_w[fdr_pkg::REFL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vs_r;
    end
    if (adv) begin
      out_refl_r <= tirs_r ? fdr_pkg::REFL_ONE : refl_sat;
      out_tir_r  <= tirs_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_reflectance    = out_refl_r;
  assign out_total_internal = out_tir_r;

endmodule

// ----- tb/fdr_checker.sv -----
// checker: predicts the fresnel reflectance of each accepted word and compares results
module fdr_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_cos_incident,
  input  logic        [15:0] in_index_outside,
  input  logic        [15:0] in_index_inside,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic        [15:0] out_reflectance,
  input  logic               out_total_internal,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] refl;
    logic        tir;
  } refl_word_t;

  refl_word_t refl_queue[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] amp_sq(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] q;
    den = a + b;
    num = (a >= b) ? a - b : b - a;
    if (den == 0) q = 64'd1 << 16;
    else q = (num << 16) / den;
    return q * q;
  endfunction

  function automatic refl_word_t fresnel_predict(input logic signed [15:0] cos_in,
                                                 input logic [15:0] n_out,
                                                 input logic [15:0] n_in);
    int cs;
    logic [63:0] ni, nt, c, s2, lhs, rhs, t, r;
    refl_word_t w;
    cs = int'(cos_in);
    if (cs > 16384) cs = 16384;
    if (cs < -16384) cs = -16384;
    if (cs > 0) begin
      ni = 64'(n_out); nt = 64'(n_in); c = 64'(cs);
    end else begin
      ni = 64'(n_in); nt = 64'(n_out); c = 64'(-cs);
    end
    s2 = (64'd1 << 28) - c * c;
    lhs = ni * ni * s2;
    rhs = (nt * nt) << 28;
    if (lhs >= rhs) begin
      w.refl = 16'd32768;
      w.tir = 1'b1;
      return w;
    end
    t = int_sqrt(rhs - lhs);
    r = (amp_sq(nt * nt * c, ni * t) + amp_sq(ni * c, t) + (64'd1 << 17)) >> 18;
    if (r > 32768) r = 32768;
    w.refl = r[15:0];
    w.tir = 1'b0;
    return w;
  endfunction

  always @(posedge clk) begin
    refl_word_t exp_w;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        refl_queue.push_back(fresnel_predict(in_cos_incident, in_index_outside,
                                             in_index_inside));
      if (out_valid && out_ready) begin
        if (refl_queue.size() == 0) begin
          $display("%0t: unexpected word refl %0d tir %0d", $time, out_reflectance,
                   out_total_internal);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = refl_queue.pop_front();
          if (exp_w.refl !== out_reflectance || exp_w.tir !== out_total_internal) begin
            $display("%0t: mismatch expected refl %0d tir %0d, actual refl %0d tir %0d",
                     $time, exp_w.refl, exp_w.tir, out_reflectance, out_total_internal);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= refl_queue.size();
  end

endmodule

// ----- tb/tb.sv -----
// testbench top: stimulus, clock, reset and verdict for the fresnel reflectance unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;  // idle cycles
  localparam int RANDOM_WORDS   = 1800;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_cos_incident = '0;
  logic        [15:0] in_index_outside = 16'd8192;
  logic        [15:0] in_index_inside = 16'd8192;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic        [15:0] out_reflectance;
  logic               out_total_internal;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;

  // half-period toggle, 10 ns clock
  always #5 clk = ~clk;

  fresnel_dielectric_reflectance_unit dut (.*);

  fdr_checker checker_i (.*);

  // watchdog: a stretch with no word accepted on either side means a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiving side: random stall per word; some runs with none
  initial begin
    int stall;
    int calm;
    calm = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!out_ready) begin
        stall = stall - 1;
        if (stall <= 0) out_ready <= 1'b1;
      end else if (out_valid) begin
        // a word leaves at this edge; decide the gap before the next one
        if (calm > 0) begin
          calm = calm - 1;
        end else begin
          if ($urandom_range(0, 40) == 0) calm = $urandom_range(20, 80);
          stall = $urandom_range(0, 11);
          if (stall > 0) out_ready <= 1'b0;
        end
      end
    end
  end

  // present one word and hold it until taken, after the given gap
  task automatic send_word(input logic signed [15:0] cos_v, input logic [15:0] n_o,
                           input logic [15:0] n_i, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cos_incident  <= cos_v;
    in_index_outside <= n_o;
    in_index_inside  <= n_i;
    in_valid         <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [15:0] pick_index();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 16'($urandom_range(8192, 8192 * 3));  // glass, water, diamond range
    if (k < 8) return 16'($urandom_range(1, 65535));
    if (k == 8) return 16'($urandom_range(0, 1) ? 1 : 65535);
    return 16'd0;
  endfunction

  function automatic logic signed [15:0] pick_cos();
    int k;
    k = $urandom_range(0, 9);
    if (k < 8) return 16'($urandom_range(0, 32768) - 16384);
    if (k == 8) return 16'($urandom_range(0, 65535));  // any 16-bit value; those beyond +-1 get clamped
    return 16'sd0;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes of cosine and indices, clamping, zero cosine, tir
    send_word(16'sd16384, 16'd8192, 16'd12288, 0);     // normal incidence entering
    send_word(-16'sd16384, 16'd8192, 16'd12288, 0);    // normal incidence leaving
    send_word(16'sd32767, 16'd8192, 16'd12288, 0);     // clamped to +1
    send_word(16'sh8000, 16'd8192, 16'd12288, 0);      // clamped to -1
    send_word(16'sd0, 16'd8192, 16'd12288, 0);         // grazing, treated as leaving
    send_word(16'sd0, 16'd0, 16'd12288, 1);            // zero outside index; treated as leaving, so total internal
    send_word(16'sd1, 16'd8192, 16'd12288, 0);         // near grazing
    send_word(-16'sd1, 16'd8192, 16'd12288, 2);
    send_word(-16'sd4000, 16'd8192, 16'd12288, 0);     // leaving glass: total internal
    send_word(16'sd8000, 16'd12288, 16'd0, 0);         // transmitted index zero
    send_word(16'sd8000, 16'd0, 16'd0, 0);
    send_word(16'sd8000, 16'd65535, 16'd1, 0);
    send_word(16'sd8000, 16'd1, 16'd65535, 3);
    send_word(-16'sd8000, 16'd65535, 16'd65535, 0);    // matched indices
    send_word(16'sd16384, 16'd65535, 16'd65535, 0);
    send_word(-16'sd12000, 16'd1, 16'd1, 0);
    send_word(16'sd5000, 16'hAAAA, 16'h5555, 0);
    send_word(-16'sd5000, 16'h5555, 16'hAAAA, 0);

    // hold off until the pipe has drained completely
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (3) @(posedge clk);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      send_word(pick_cos(), pick_index(), pick_index(), pick_gap());
      if (i == RANDOM_WORDS / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
